FILE: rtl/core/dsm_pkg.sv
package dsm_pkg;

   localparam int AccumWidth  = 32;
   localparam int WeightWidth = 25;
   localparam int ProdWidth   = AccumWidth + WeightWidth;
   localparam int TotalWidth  = 64;
   localparam int RankWidth   = 3;

   // Designator ranks, in the order they must appear.
   localparam logic [RankWidth-1:0] RANK_NONE   = 3'd0;
   localparam logic [RankWidth-1:0] RANK_YEAR   = 3'd1;
   localparam logic [RankWidth-1:0] RANK_MONTH  = 3'd2;
   localparam logic [RankWidth-1:0] RANK_DAY    = 3'd3;
   localparam logic [RankWidth-1:0] RANK_HOUR   = 3'd4;
   localparam logic [RankWidth-1:0] RANK_MINUTE = 3'd5;
   localparam logic [RankWidth-1:0] RANK_SECOND = 3'd6;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } req_type;

   typedef struct packed {
      logic                  valid_res;
      logic [TotalWidth-1:0] milliseconds;
   } rsp_type;

   // One parsed character: its product term in seconds, and the verdict on a last beat.
   typedef struct packed {
      logic                 last;
      logic                 ok;
      logic [ProdWidth-1:0] prod;
   } term_type;

   // Finished string: verdict and total in seconds, modulo 2^64.
   typedef struct packed {
      logic                  ok;
      logic [TotalWidth-1:0] sum_s;
   } fin_type;

   // Unit weights in seconds; the factor of 1000 is applied once at the output.
   function automatic logic [WeightWidth-1:0] scaled_weight(logic [RankWidth-1:0] rank);
      logic [WeightWidth-1:0] w;
      case (rank)
         RANK_YEAR:   w = 25'd31556952;
         RANK_MONTH:  w = 25'd2629800;
         RANK_DAY:    w = 25'd86400;
         RANK_HOUR:   w = 25'd3600;
         RANK_MINUTE: w = 25'd60;
         RANK_SECOND: w = 25'd1;
         default:     w = '0;
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/duration_string_to_milliseconds.sv
// Streaming ISO 8601 duration parser (PnYnMnDTnHnMnS). Feed one ASCII character
// per req beat, with last set on the final character; exactly one rsp beat
// comes back per string, carrying valid_res and the total in milliseconds
// (modulo 2^64, zero when the string is malformed). The block takes one
// character every cycle while req_stall is low. The path runs through four
// registers: input register, parse and multiply, running sum, and the output
// register, which applies the seconds-to-milliseconds scale. The last character
// of a string and then its result pass through them in turn on the way to rsp.
// Up to two finished results can wait on rsp_stall without holding up the
// characters of later strings: one in the output register and one in the sum
// stage. The last character of a third string backs up behind them and stalls the input.
module duration_string_to_milliseconds (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dsm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dsm_pkg::rsp_type rsp_payload
);
   import dsm_pkg::*;

   // input register
   logic     req_v_ff;
   req_type  req_ff;
   logic     parse_take;

   // parse to sum
   logic     term_valid;
   term_type term_beat;
   logic     term_ready;

   // sum to output
   logic     fin_valid;
   fin_type  fin_beat;
   logic     fin_ready;

   // output register
   logic                  rsp_v_ff;
   rsp_type               rsp_ff;
   logic [TotalWidth-1:0] ms_scaled;

   // Hold the input beat while the parse stage cannot take it.
   assign req_stall = req_v_ff && !parse_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         req_v_ff <= 1'b1;
      end else if (parse_take) begin
         req_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_payload;
      end
   end

   // Check grammar, collect digits, form value * unit-in-seconds per designator.
   dsm_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_v_ff),
      .in_beat   (req_ff),
      .in_take   (parse_take),
      .out_valid (term_valid),
      .out_beat  (term_beat),
      .out_ready (term_ready)
   );

   // Add the terms up per string; release the sum on the last beat.
   dsm_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .term_valid (term_valid),
      .term_beat  (term_beat),
      .term_ready (term_ready),
      .fin_valid  (fin_valid),
      .fin_beat   (fin_beat),
      .fin_ready  (fin_ready)
   );

   // seconds * 1000 = s*1024 - s*16 - s*8, wrapping at 64 bits
   assign ms_scaled = (fin_beat.sum_s << 10) - (fin_beat.sum_s << 4)
                    - (fin_beat.sum_s << 3);

   assign fin_ready = !rsp_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (fin_valid && fin_ready) begin
         rsp_v_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid && fin_ready) begin
         rsp_ff.valid_res    <= fin_beat.ok;
         rsp_ff.milliseconds <= fin_beat.ok ? ms_scaled : '0;
      end
   end

   assign rsp_valid   = rsp_v_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/core/dsm_parse.sv
module dsm_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  dsm_pkg::req_type  in_beat,
   output logic              in_take,
   output logic              out_valid,
   output dsm_pkg::term_type out_beat,
   input  logic              out_ready
);
   import dsm_pkg::*;

   localparam logic [1:0] PH_EXPECT_P = 2'd0;
   localparam logic [1:0] PH_DATE     = 2'd1;
   localparam logic [1:0] PH_TIME     = 2'd2;
   localparam logic [1:0] PH_ERROR    = 2'd3;

   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_9 = 8'h39;
   localparam logic [7:0] CHAR_D = 8'h44;
   localparam logic [7:0] CHAR_H = 8'h48;
   localparam logic [7:0] CHAR_M = 8'h4D;
   localparam logic [7:0] CHAR_P = 8'h50;
   localparam logic [7:0] CHAR_S = 8'h53;
   localparam logic [7:0] CHAR_T = 8'h54;
   localparam logic [7:0] CHAR_Y = 8'h59;

   logic [1:0]            phase_ff, phase_in;
   logic [AccumWidth-1:0] accum_ff, accum_in;
   logic                  digits_ff, digits_in;
   logic [RankWidth-1:0]  rank_ff, rank_in;
   logic                  seen_ff, seen_in;
   logic                  term_v_ff;
   term_type              term_ff;

   logic [7:0]             c;
   logic                   is_digit;
   logic                   is_t;
   logic [RankWidth-1:0]   rank_sel;
   logic [AccumWidth+3:0]  grown;
   logic [WeightWidth-1:0] weight;
   logic [ProdWidth-1:0]   prod;
   logic                   ok;

   assign in_take   = in_valid && (!term_v_ff || out_ready);
   assign out_valid = term_v_ff;
   assign out_beat  = term_ff;

   assign c        = in_beat.char_code;
   assign is_digit = c inside {[CHAR_0:CHAR_9]};
   // accum * 10 + digit; low nibble of an ASCII digit is its value
   assign grown = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                + {{AccumWidth{1'b0}}, c[3:0]};

   always_comb begin
      rank_sel = RANK_NONE;
      is_t     = 1'b0;
      if (phase_ff == PH_DATE) begin
         case (c)
            CHAR_Y:  rank_sel = RANK_YEAR;
            CHAR_M:  rank_sel = RANK_MONTH;
            CHAR_D:  rank_sel = RANK_DAY;
            CHAR_T:  is_t = 1'b1;
            default: rank_sel = RANK_NONE;
         endcase
      end else begin
         case (c)
            CHAR_H:  rank_sel = RANK_HOUR;
            CHAR_M:  rank_sel = RANK_MINUTE;
            CHAR_S:  rank_sel = RANK_SECOND;
            default: rank_sel = RANK_NONE;
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      digits_in = digits_ff;
      rank_in   = rank_ff;
      seen_in   = seen_ff;
      weight    = '0;
      if (phase_ff == PH_ERROR) begin
         phase_in = PH_ERROR;
      end else if (phase_ff == PH_EXPECT_P) begin
         phase_in = (c == CHAR_P) ? PH_DATE : PH_ERROR;
      end else if (is_digit) begin
         if (|grown[AccumWidth+3:AccumWidth]) begin
            phase_in = PH_ERROR;
         end else begin
            accum_in  = grown[AccumWidth-1:0];
            digits_in = 1'b1;
         end
      end else if (is_t) begin
         phase_in = digits_ff ? PH_ERROR : PH_TIME;
      end else if (rank_sel == RANK_NONE || !digits_ff || rank_sel <= rank_ff) begin
         phase_in = PH_ERROR;
      end else begin
         weight    = scaled_weight(rank_sel);
         rank_in   = rank_sel;
         accum_in  = '0;
         digits_in = 1'b0;
         if (rank_sel >= RANK_HOUR) begin
            seen_in = 1'b1;
         end
      end
   end

   assign prod = {{WeightWidth{1'b0}}, accum_ff} * {{AccumWidth{1'b0}}, weight};

   assign ok = (phase_in == PH_DATE || phase_in == PH_TIME) && !digits_in
             && (rank_in != RANK_NONE) && (phase_in != PH_TIME || seen_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_EXPECT_P;
         accum_ff  <= '0;
         digits_ff <= 1'b0;
         rank_ff   <= RANK_NONE;
         seen_ff   <= 1'b0;
         term_v_ff <= 1'b0;
      end else begin
         if (in_take) begin
            if (in_beat.last) begin
               phase_ff  <= PH_EXPECT_P;
               accum_ff  <= '0;
               digits_ff <= 1'b0;
               rank_ff   <= RANK_NONE;
               seen_ff   <= 1'b0;
            end else begin
               phase_ff  <= phase_in;
               accum_ff  <= accum_in;
               digits_ff <= digits_in;
               rank_ff   <= rank_in;
               seen_ff   <= seen_in;
            end
            term_v_ff <= 1'b1;
         end else if (out_ready) begin
            term_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         term_ff.last <= in_beat.last;
         term_ff.ok   <= ok;
         term_ff.prod <= prod;
      end
   end

endmodule

FILE: rtl/core/dsm_accum.sv
module dsm_accum (
   input  logic              clock,
   input  logic              reset,
   input  logic              term_valid,
   input  dsm_pkg::term_type term_beat,
   output logic              term_ready,
   output logic              fin_valid,
   output dsm_pkg::fin_type  fin_beat,
   input  logic              fin_ready
);
   import dsm_pkg::*;

   logic [TotalWidth-1:0] sum_ff, sum_in;
   logic                  fin_v_ff;
   fin_type               fin_ff;
   logic                  take;

   // Only a last beat needs room downstream; others fold into the sum.
   assign term_ready = !term_beat.last || !fin_v_ff || fin_ready;
   assign take       = term_valid && term_ready;
   assign sum_in     = sum_ff + {{(TotalWidth-ProdWidth){1'b0}}, term_beat.prod};
   assign fin_valid  = fin_v_ff;
   assign fin_beat   = fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         fin_v_ff <= 1'b0;
      end else begin
         if (take) begin
            sum_ff <= term_beat.last ? '0 : sum_in;
         end
         if (take && term_beat.last) begin
            fin_v_ff <= 1'b1;
         end else if (fin_ready) begin
            fin_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && term_beat.last) begin
         fin_ff.ok    <= term_beat.ok;
         fin_ff.sum_s <= sum_in;
      end
   end

endmodule
